### rtl/core/x_matrix_add_multiply_core_macros.svh
// Assertion macros used by the block's checker.
// No dependencies; the including scope must provide clk_i and rst_ni.
`ifndef X_MATRIX_ADD_MULTIPLY_CORE_MACROS_SVH
`define X_MATRIX_ADD_MULTIPLY_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define XMAM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xmam: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define XMAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xmam: next-cycle check failed");

`endif

### rtl/core/xmam_pkg.sv
// Shared types and constants of the X-matrix add/multiply block.
// No dependencies.
package xmam_pkg;

  localparam int unsigned SizeW  = 4;
  localparam int unsigned EntryW = 16;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned ResW   = 33;

  typedef enum logic [0:0] {
    REG_MATRIX_SIZE = 1'b0,
    REG_MODE        = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CELL,
    ST_TERM1,
    ST_ACC1,
    ST_TERM2,
    ST_ACC2,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_CLEAR,
    DP_SUM,
    DP_MUL,
    DP_LOAD_PROD,
    DP_ADD_PROD
  } dp_op_e;

  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    dp_op_e op;
  } dp_cmd_t;

endpackage

### rtl/core/xmam_dp.sv
// Datapath: entry stores for A and B, multiplier and result accumulator.
// Depends on xmam_pkg; driven by xmam_ctrl through dp_cmd_t.
module xmam_dp #(
  parameter int unsigned StoreDepth = 16,
  parameter int unsigned AddrW      = 4
) (
  input  logic                                  clk_i,
  input  xmam_pkg::dp_cmd_t                     cmd_i,
  input  logic [AddrW-1:0]                      wr_addr_i,
  input  logic [AddrW-1:0]                      rd_addr_a_i,
  input  logic [AddrW-1:0]                      rd_addr_b_i,
  input  logic signed [xmam_pkg::EntryW-1:0]    a_entry_i,
  input  logic signed [xmam_pkg::EntryW-1:0]    b_entry_i,
  output logic signed [xmam_pkg::ResW-1:0]      result_o
);
  import xmam_pkg::*;

  logic signed [EntryW-1:0] a_mem [StoreDepth];
  logic signed [EntryW-1:0] b_mem [StoreDepth];
  logic signed [EntryW-1:0] a_rd_q, b_rd_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [ResW-1:0]   acc_q, acc_d;
  logic signed [ResW-1:0]   prod_ext, sum_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      a_mem[wr_addr_i] <= a_entry_i;
      b_mem[wr_addr_i] <= b_entry_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= a_mem[rd_addr_a_i];
      b_rd_q <= b_mem[rd_addr_b_i];
    end
  end

  assign prod_ext = {prod_q[ProdW-1], prod_q};
  assign sum_ext  = {{(ResW-EntryW){a_rd_q[EntryW-1]}}, a_rd_q}
                  + {{(ResW-EntryW){b_rd_q[EntryW-1]}}, b_rd_q};

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    case (cmd_i.op)
      DP_CLEAR:     acc_d  = '0;
      DP_SUM:       acc_d  = sum_ext;
      DP_MUL:       prod_d = a_rd_q * b_rd_q;
      DP_LOAD_PROD: acc_d  = prod_ext;
      DP_ADD_PROD:  acc_d  = acc_q + prod_ext;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign result_o = acc_q;

endmodule

### rtl/core/xmam_ctrl.sv
// Controller: load counter, cell sweep counters and sequencing FSM.
// Depends on xmam_pkg; commands xmam_dp.
module xmam_ctrl #(
  parameter int unsigned AddrW = 4,
  parameter int unsigned RowW  = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [xmam_pkg::SizeW-1:0]    n_i,
  input  logic                          mode_i,
  input  logic                          size_wr_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [RowW-1:0]               row_o,
  output logic [RowW-1:0]               col_o,
  output logic                          final_cell_o,
  output xmam_pkg::dp_cmd_t             cmd_o,
  output logic [AddrW-1:0]              wr_addr_o,
  output logic [AddrW-1:0]              rd_addr_a_o,
  output logic [AddrW-1:0]              rd_addr_b_o
);
  import xmam_pkg::*;

  // store index of X entry (r, c), entries packed row-major
  function automatic logic [SizeW:0] x_pos(logic [SizeW-1:0] r, logic [SizeW-1:0] c,
                                           logic [SizeW-1:0] n);
    logic [SizeW-1:0] mirror;
    logic [SizeW-1:0] lo;
    logic [SizeW-1:0] half;
    logic [SizeW:0]   base;
    mirror = n - SizeW'(1) - r;
    lo     = (r < mirror) ? r : mirror;
    half   = (n - SizeW'(1)) >> 1;
    base   = (n[0] && (r > half)) ? ({r, 1'b0} - (SizeW+1)'(1)) : {r, 1'b0};
    return base + ((c > lo) ? (SizeW+1)'(1) : (SizeW+1)'(0));
  endfunction

  ctrl_state_e state_q, state_d;
  logic [AddrW-1:0] load_cnt_q, load_cnt_d;
  logic [RowW-1:0]  row_q, row_d, col_q, col_d;

  logic [SizeW:0]   load_len;
  logic             last_load;
  logic [SizeW-1:0] ie, je, mi;
  logic             on_x, center, last_cell;
  logic             in_xfer, out_xfer;

  assign load_len  = n_i[0] ? ({n_i, 1'b0} - (SizeW+1)'(1)) : {n_i, 1'b0};
  assign last_load = ((SizeW+1)'(load_cnt_q) == load_len - (SizeW+1)'(1));

  assign ie        = SizeW'(row_q);
  assign je        = SizeW'(col_q);
  assign mi        = n_i - SizeW'(1) - ie;
  assign on_x      = (je == ie) || (je == mi);
  assign center    = (ie == mi);
  assign last_cell = (ie == n_i - SizeW'(1)) && (je == n_i - SizeW'(1));

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_xfer && last_load && !size_wr_i) state_d = ST_CELL;
      ST_CELL:  state_d = on_x ? ST_TERM1 : ST_OUT;
      ST_TERM1: state_d = mode_i ? ST_ACC1 : ST_OUT;
      ST_ACC1:  state_d = center ? ST_OUT : ST_TERM2;
      ST_TERM2: state_d = ST_ACC2;
      ST_ACC2:  state_d = ST_OUT;
      ST_OUT:   if (out_xfer) state_d = last_cell ? ST_LOAD : ST_CELL;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '{wr_en: 1'b0, rd_en: 1'b0, op: DP_HOLD};
    rd_addr_a_o = AddrW'(x_pos(ie, je, n_i));
    rd_addr_b_o = AddrW'(x_pos(ie, je, n_i));
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.wr_en  = in_xfer;
      end
      ST_CELL: begin
        if (on_x) begin
          cmd_o.rd_en = 1'b1;
          if (mode_i) rd_addr_a_o = AddrW'(x_pos(ie, ie, n_i));
        end else begin
          cmd_o.op = DP_CLEAR;
        end
      end
      ST_TERM1: cmd_o.op = mode_i ? DP_MUL : DP_SUM;
      ST_ACC1: begin
        cmd_o.op    = DP_LOAD_PROD;
        cmd_o.rd_en = !center;
        rd_addr_a_o = AddrW'(x_pos(ie, mi, n_i));
        rd_addr_b_o = AddrW'(x_pos(mi, je, n_i));
      end
      ST_TERM2: cmd_o.op = DP_MUL;
      ST_ACC2:  cmd_o.op = DP_ADD_PROD;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    if (in_xfer) begin
      if (last_load) begin
        load_cnt_d = '0;
        row_d      = '0;
        col_d      = '0;
      end else begin
        load_cnt_d = load_cnt_q + AddrW'(1);
      end
    end
    if (size_wr_i) load_cnt_d = '0;
    if (out_xfer && !last_cell) begin
      if (je == n_i - SizeW'(1)) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  assign wr_addr_o    = load_cnt_q;
  assign row_o        = row_q;
  assign col_o        = col_q;
  assign final_cell_o = last_cell;

endmodule

### rtl/core/x_matrix_add_multiply_core.sv
// Top level of the X-matrix add/multiply block: APB registers, controller, datapath.
// Depends on xmam_pkg, xmam_ctrl and xmam_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one X entry of A and of B per
//   transfer, row-major over the X positions: 2n entries, or 2n-1 for odd n.
//   Entries load one per cycle; in_ready_o is high whenever a load is open.
//   After the last entry the block streams all n*n cells on the output channel
//   (out_valid_o/out_ready_i), row-major, final_cell_o set on the last one.
//   Per cell the sequencer steps CELL, OUT off the X; CELL, TERM1, OUT for a
//   sum; CELL, TERM1, ACC1, OUT for the center product; and CELL, TERM1,
//   ACC1, TERM2, ACC2, OUT for other product cells (two multiply passes
//   through the one shared multiplier and single-port store reads); the first
//   cell is always on the diagonal. Input is closed during the burst.
//   A stalled receiver holds the current cell in place; nothing is dropped.
//   Reset: matrix_size 2, mode 0 (sum), empty load; store contents undefined.
//   Writing matrix_size restarts the load. Registers: 0 matrix_size, 4 mode.
module x_matrix_add_multiply_core #(
  parameter int unsigned MAX_N = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [xmam_pkg::EntryW-1:0]  a_entry_i,
  input  logic signed [xmam_pkg::EntryW-1:0]  b_entry_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [xmam_pkg::ResW-1:0]    result_value_o,
  output logic [$clog2(MAX_N)-1:0]            row_o,
  output logic [$clog2(MAX_N)-1:0]            col_o,
  output logic                                final_cell_o
);
  import xmam_pkg::*;

  localparam int unsigned StoreDepth = 2 * MAX_N;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned RowW       = $clog2(MAX_N);

  logic [SizeW-1:0] size_q, size_d;
  logic             mode_q, mode_d;
  logic             cfg_wr, size_wr;
  logic [SizeW-1:0] n_eff;
  cfg_reg_e         reg_sel;

  dp_cmd_t          cmd;
  logic [AddrW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    size_d  = size_q;
    mode_d  = mode_q;
    size_wr = 1'b0;
    prdata  = '0;
    unique case (reg_sel)
      REG_MATRIX_SIZE: begin
        prdata = 32'(size_q);
        if (cfg_wr) begin
          size_d  = pwdata[SizeW-1:0];
          size_wr = 1'b1;
        end
      end
      REG_MODE: begin
        prdata = 32'(mode_q);
        if (cfg_wr) mode_d = pwdata[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(2);
      mode_q <= 1'b0;
    end else begin
      size_q <= size_d;
      mode_q <= mode_d;
    end
  end

  assign n_eff = (size_q < SizeW'(2))     ? SizeW'(2)     :
                 (size_q > SizeW'(MAX_N)) ? SizeW'(MAX_N) : size_q;

  xmam_ctrl #(
    .AddrW (AddrW),
    .RowW  (RowW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_eff),
    .mode_i       (mode_q),
    .size_wr_i    (size_wr),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_o        (row_o),
    .col_o        (col_o),
    .final_cell_o (final_cell_o),
    .cmd_o        (cmd),
    .wr_addr_o    (wr_addr),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b)
  );

  xmam_dp #(
    .StoreDepth (StoreDepth),
    .AddrW      (AddrW)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .a_entry_i   (a_entry_i),
    .b_entry_i   (b_entry_i),
    .result_o    (result_value_o)
  );

endmodule

### rtl/core/xmam_checker.sv
// Port-level checks for x_matrix_add_multiply_core, attached by bind.
// Depends on x_matrix_add_multiply_core_macros.svh and xmam_pkg.
`include "x_matrix_add_multiply_core_macros.svh"

module xmam_checker #(
  parameter int unsigned RowW = 3
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [xmam_pkg::ResW-1:0]  result_value_o,
  input logic [RowW-1:0]                   row_o,
  input logic [RowW-1:0]                   col_o,
  input logic                              final_cell_o
);

  // load and result burst never overlap
  `XMAM_ASSERT_SAME(a_no_overlap, out_valid_o, !in_ready_o)

  // stalled cell holds
  `XMAM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(result_value_o) && $stable(row_o) && $stable(col_o))

  // last cell transfer reopens the load, any other keeps it closed
  `XMAM_ASSERT_NEXT(a_reopen, out_valid_o && out_ready_i && final_cell_o, in_ready_o)
  `XMAM_ASSERT_NEXT(a_stay_closed, out_valid_o && out_ready_i && !final_cell_o, !in_ready_o)

  // last cell sits on the diagonal corner
  `XMAM_ASSERT_SAME(a_final_corner, out_valid_o && final_cell_o, row_o == col_o)

endmodule

bind x_matrix_add_multiply_core xmam_checker #(
  .RowW (RowW)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o),
  .row_o          (row_o),
  .col_o          (col_o),
  .final_cell_o   (final_cell_o)
);
